/* src/lrupr_pkg.sv */
package lrupr_pkg;

    localparam int FRAMES_DEFAULT    = 8;
    localparam int NUM_PAGES_DEFAULT = 256;

    localparam int PAGE_W      = 8;
    localparam int CFG_W       = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd8;

    // register indexes (byte address = 4 * index)
    localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = 2'd0;

endpackage

/* src/lru_page_replacement_core.sv */
// LRU page replacement over FRAMES frames, one page reference per item.
// The result item is registered and valid in the cycle after the input item is accepted.
// Throughput: 1 item per cycle unless m_tready stalls a held result; parallel tag compare
//   and one-step slot shift finish in the accept cycle; back-to-back refs see fresh order.
// Reset (aresetn low, synchronous): fill count 0, frames_in_use 8, no result pending;
//   slot contents are not cleared, only slots below the fill count are ever read.
module lru_page_replacement_core #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEFAULT,
    parameter int NUM_PAGES = lrupr_pkg::NUM_PAGES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrupr_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] page

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrupr_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] hit, [1] evicted_valid,
                                                           // [9:2] evicted_page, [15:10] zero

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int CW = $clog2(FRAMES + 1);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = lrupr_pkg::PAGE_W;
    localparam int FW = lrupr_pkg::CFG_W;

    logic [PW-1:0] slots_reg  [FRAMES];
    logic [PW-1:0] slots_next [FRAMES];
    logic [CW-1:0] fill_reg, fill_next;
    logic [FW-1:0] frames_reg, frames_next;

    logic                      out_valid_reg, out_valid_next;
    logic [lrupr_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [PW-1:0] page;
    logic          page_ok;
    logic          in_acc;
    logic          cfg_wr;
    logic          found;
    logic [IW-1:0] found_idx;
    logic [CW-1:0] lim;
    logic [CW-1:0] cfg_lim;
    logic          full;
    logic [CW-1:0] upto;
    logic [IW-1:0] last_idx;
    logic [CW-1:0] last_cnt;
    logic          hit_c, evict_c;
    logic [PW-1:0] evict_page_c;

    // frame limit from a 4-bit register value: zero acts as 1, saturate at FRAMES
    function automatic logic [CW-1:0] frame_limit(input logic [FW-1:0] f);
        int unsigned v;
        v = 32'(f);
        if (v < 1) v = 1;
        if (v > FRAMES) v = FRAMES;
        return CW'(v);
    endfunction

    assign pready   = 1'b1;
    assign prdata   = {{(lrupr_pkg::APB_DATA_W-FW){1'b0}}, frames_reg};
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign page    = s_tdata[PW-1:0];
    assign page_ok = (32'(page) < NUM_PAGES);
    assign in_acc  = s_tvalid && s_tready;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[lrupr_pkg::APB_ADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE);

    assign lim     = frame_limit(frames_reg);
    assign cfg_lim = frame_limit(pwdata[FW-1:0]);
    assign full    = (fill_reg >= lim);
    assign last_cnt = fill_reg - CW'(1);
    assign last_idx = last_cnt[IW-1:0];

    // tag match; pages in the slots are distinct, lowest index wins
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((CW'(i) < fill_reg) && (slots_reg[i] == page)) begin
                found     = 1'b1;
                found_idx = IW'(i);
            end
        end
    end

    always_comb begin
        hit_c        = page_ok && found;
        evict_c      = page_ok && !found && full;
        evict_page_c = evict_c ? slots_reg[last_idx] : '0;

        if (found)
            upto = CW'(found_idx);
        else if (full)
            upto = last_cnt;
        else
            upto = fill_reg;

        slots_next[0] = page;
        for (int i = 1; i < FRAMES; i++) begin
            slots_next[i] = (CW'(i) <= upto) ? slots_reg[i-1] : slots_reg[i];
        end

        fill_next   = fill_reg;
        frames_next = frames_reg;
        if (cfg_wr) begin
            frames_next = pwdata[FW-1:0];
            if (fill_reg > cfg_lim)
                fill_next = cfg_lim;
        end else if (in_acc && page_ok && !found && !full) begin
            fill_next = fill_reg + CW'(1);
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_acc) begin
            out_valid_next = 1'b1;
            out_data_next  = {{(lrupr_pkg::OUT_DATA_W-PW-2){1'b0}},
                              evict_page_c, evict_c, hit_c};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            frames_reg    <= lrupr_pkg::FRAMES_IN_USE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        if (in_acc && page_ok) begin
            for (int i = 0; i < FRAMES; i++) begin
                slots_reg[i] <= slots_next[i];
            end
        end
    end

    a_fill_le_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= lim)
        else $error("fill count above frame limit");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and eviction in one result");

    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[PW+1:2] == '0))
        else $error("evicted page nonzero without eviction");

    a_hit_keeps_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && hit_c && !cfg_wr) |=> $stable(fill_reg))
        else $error("fill count changed on hit");

    a_evict_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !cfg_wr && evict_c) |=> (fill_reg == $past(fill_reg)) && m_tdata[1])
        else $error("eviction changed fill count or was not reported");

endmodule

/* test/tb_lru_page_replacement_core.sv */
module tb_lru_page_replacement_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES      = lrupr_pkg::FRAMES_DEFAULT;
    localparam int PAGE_W      = lrupr_pkg::PAGE_W;
    localparam int CFG_W       = lrupr_pkg::CFG_W;
    localparam int APB_ADDR_W  = lrupr_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = lrupr_pkg::APB_DATA_W;
    localparam int IN_DATA_W   = lrupr_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = lrupr_pkg::OUT_DATA_W;
    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR = {lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};

    // same bit order as m_tdata: hit in bit 0
    typedef struct packed {
        logic [5:0]        pad;
        logic [PAGE_W-1:0] evicted_page;
        logic              evicted_valid;
        logic              hit;
    } lru_outcome_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;    // [7:0] page
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [0] hit, [1] evicted_valid, [9:2] evicted_page
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [PAGE_W-1:0]     lru_slot [FRAMES];
    int                    resident_count = 0;
    logic [CFG_W-1:0]      frames_reg     = lrupr_pkg::FRAMES_IN_USE_RESET;
    lru_outcome_t          pending_results [$];

    int                    err_count     = 0;
    int                    quiet_cycles  = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    lru_outcome_t          got_result;
    lru_outcome_t          want_result;

    lru_page_replacement_core #(
        .FRAMES    (FRAMES),
        .NUM_PAGES (lrupr_pkg::NUM_PAGES_DEFAULT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    function automatic int active_limit();
        if (frames_reg == 0) return 1;
        if (frames_reg > FRAMES) return FRAMES;
        return int'(frames_reg);
    endfunction

    task automatic set_frame_limit(input logic [CFG_W-1:0] raw);
        frames_reg = raw;
        // pages beyond the new limit are dropped without an eviction
        if (resident_count > active_limit()) resident_count = active_limit();
    endtask

    task automatic lru_reference(input logic [PAGE_W-1:0] pg);
        lru_outcome_t res;
        int found;
        int upto;
        res = '0;
        found = -1;
        for (int i = 0; i < resident_count; i++) begin
            if (found < 0 && lru_slot[i] == pg) found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            upto = found;
        end else if (resident_count >= active_limit()) begin
            res.evicted_valid = 1'b1;
            res.evicted_page  = lru_slot[resident_count-1];
            upto = resident_count - 1;
        end else begin
            upto = resident_count;
            resident_count++;
        end
        for (int i = upto; i > 0; i--) begin
            if (i < FRAMES) lru_slot[i] = lru_slot[i-1];
        end
        lru_slot[0] = pg;
        pending_results.push_back(res);
    endtask

    // result side: compare, randomize backpressure, track idle cycles
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = m_tdata;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result item", 0, 32'(m_tdata));
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.hit !== want_result.hit)
                    note_mismatch("hit", 32'(want_result.hit), 32'(got_result.hit));
                if (got_result.evicted_valid !== want_result.evicted_valid)
                    note_mismatch("evicted_valid", 32'(want_result.evicted_valid),
                                  32'(got_result.evicted_valid));
                if (got_result.evicted_page !== want_result.evicted_page)
                    note_mismatch("evicted_page", 32'(want_result.evicted_page),
                                  32'(got_result.evicted_page));
                if (got_result.pad !== want_result.pad)
                    note_mismatch("tdata padding", 32'(want_result.pad),
                                  32'(got_result.pad));
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // valid is left high after acceptance so back-to-back items need no toggle
    task automatic send_page(input logic [PAGE_W-1:0] pg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pg;
        do @(posedge aclk); while (!s_tready);
        lru_reference(pg);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == FRAMES_ADDR) set_frame_limit(data[CFG_W-1:0]);
        @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) note_mismatch("frames_in_use readback", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure_frames(input logic [CFG_W-1:0] raw);
        drain_results();
        apb_write(FRAMES_ADDR, {{(APB_DATA_W-CFG_W){1'b0}}, raw});
        apb_read_check(FRAMES_ADDR, {{(APB_DATA_W-CFG_W){1'b0}}, raw});
    endtask

    task automatic test_reset_value();
        apb_read_check(FRAMES_ADDR,
                       {{(APB_DATA_W-CFG_W){1'b0}}, lrupr_pkg::FRAMES_IN_USE_RESET});
    endtask

    // fill all frames, hit at most-recent, middle and least-recent slots, evict
    task automatic test_directed_refs();
        logic [PAGE_W-1:0] seq [$];
        seq = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h02,
                8'h80, 8'h7F, 8'hFF, 8'h10, 8'h00, 8'h55, 8'hAA, 8'h7F,
                8'hC3, 8'h3C};
        foreach (seq[i]) send_page(seq[i]);
    endtask

    task automatic test_frame_limits();
        // lowering below the resident count drops the oldest pages silently
        configure_frames(4'd3);
        send_page(8'h3C);
        send_page(8'h11);
        send_page(8'hAA);
        send_page(8'h22);
        // zero behaves as a single frame
        configure_frames(4'd0);
        send_page(8'h22);
        send_page(8'h22);
        send_page(8'h33);
        // above the frame count saturates
        configure_frames(4'd15);
        for (int i = 0; i < 10; i++) send_page(PAGE_W'(i + 'h40));
        send_page(8'h40);
        configure_frames(4'd1);
        send_page(8'h49);
        send_page(8'h48);
        // other register slots are ignored
        drain_results();
        for (int idx = 1; idx < 4; idx++) begin
            apb_write({idx[1:0], 2'b00}, $urandom());
        end
        apb_read_check(FRAMES_ADDR, {{(APB_DATA_W-CFG_W){1'b0}}, frames_reg});
        send_page(8'h48);
        send_page(8'h01);
        configure_frames(4'd8);
    endtask

    task automatic test_random_refs(input int idle_pct, input int stall_pct,
                                    input logic [CFG_W-1:0] lim_a,
                                    input logic [CFG_W-1:0] lim_b,
                                    input logic [CFG_W-1:0] lim_c);
        logic [CFG_W-1:0]  lims [3];
        logic [PAGE_W-1:0] pool_mask;
        logic [PAGE_W-1:0] pg;
        lims = '{lim_a, lim_b, lim_c};
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        foreach (lims[k]) begin
            configure_frames(lims[k]);
            pool_mask = PAGE_W'($urandom_range(255));
            repeat (100) begin
                // mostly a small working set so hits and evictions both occur
                if ($urandom_range(99) < 70) pg = pool_mask ^ PAGE_W'($urandom_range(11));
                else pg = PAGE_W'($urandom_range(255));
                send_page(pg);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_value();
        test_directed_refs();
        test_frame_limits();
        test_random_refs(0, 0, 4'd8, 4'd2, 4'd15);
        test_random_refs(80, 0, 4'd1, 4'd5, 4'd0);
        test_random_refs(0, 80, 4'd4, 4'd9, 4'd7);
        test_random_refs(15, 15, 4'd3, 4'd6, 4'd12);

        drain_results();
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
src/lrupr_pkg.sv
src/lru_page_replacement_core.sv
test/tb_lru_page_replacement_core.sv
